FILE: hw/rtl/hamming_window_violation_check_macros.svh
// ----------------------------------------------------------------------------
// Hamming window violation check - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HAMMING_WINDOW_VIOLATION_CHECK_MACROS_SVH
`define HAMMING_WINDOW_VIOLATION_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define HWVC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HWVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hwvc_pkg.sv
// ----------------------------------------------------------------------------
// hwvc_pkg
// Types, codes and helpers shared by the Hamming window violation checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwvc_pkg;

    localparam int WORD_W = 64;
    localparam int POP_W  = 7;
    localparam int REG_W  = 9;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd1;

    localparam logic [REG_W-1:0] MAX_DIST_RESET = 9'd182;
    localparam logic [REG_W-1:0] MIN_DIST_RESET = 9'd182;
    localparam logic [REG_W-1:0] VIOL_MAX       = 9'd511;

    // Item modes
    typedef enum logic [1:0] {
        MODE_TABLE = 2'd0,
        MODE_CAND  = 2'd1,
        MODE_CHECK = 2'd2
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } state_t;

    // Tag that travels with each word read from the store
    typedef struct packed {
        logic valid;
        logic last_word;
        logic last_row;
    } word_tag_t;

    // Status of the window evaluator
    typedef struct packed {
        logic             done;
        logic [REG_W-1:0] violation;
    } eval_stat_t;

    // 64-bit popcount as a six level adder tree
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] v;
        v = (x & 64'h5555_5555_5555_5555) + ((x >> 1) & 64'h5555_5555_5555_5555);
        v = (v & 64'h3333_3333_3333_3333) + ((v >> 2) & 64'h3333_3333_3333_3333);
        v = (v & 64'h0F0F_0F0F_0F0F_0F0F) + ((v >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
        v = (v & 64'h00FF_00FF_00FF_00FF) + ((v >> 8) & 64'h00FF_00FF_00FF_00FF);
        v = (v & 64'h0000_FFFF_0000_FFFF) + ((v >> 16) & 64'h0000_FFFF_0000_FFFF);
        v = (v & 64'h0000_0000_FFFF_FFFF) + ((v >> 32) & 64'h0000_0000_FFFF_FFFF);
        return v[POP_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/hwvc_row_store.sv
// ----------------------------------------------------------------------------
// hwvc_row_store
// Table memory and candidate memory, one write and one registered read each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwvc_row_store #(
    parameter int DEPTH  = 1542,
    parameter int AW     = 11,
    parameter int CDEPTH = 6,
    parameter int CW     = 3
) (
    input  logic                       clk,
    input  logic                       tbl_we,
    input  logic [AW-1:0]              tbl_waddr,
    input  logic                       cand_we,
    input  logic [CW-1:0]              cand_waddr,
    input  logic [hwvc_pkg::WORD_W-1:0] wdata,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_taddr,
    input  logic [CW-1:0]              rd_caddr,
    output logic [hwvc_pkg::WORD_W-1:0] tbl_q,
    output logic [hwvc_pkg::WORD_W-1:0] cand_q
);
    import hwvc_pkg::*;

    logic [WORD_W-1:0] tbl_mem  [DEPTH];
    logic [WORD_W-1:0] cand_mem [CDEPTH];

    // Table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= wdata;
        end
        if (rd_en)
        begin
            tbl_q <= tbl_mem[rd_taddr];
        end
    end

    // Candidate memory, read in step with the table
    always_ff @(posedge clk)
    begin
        if (cand_we)
        begin
            cand_mem[cand_waddr] <= wdata;
        end
        if (rd_en)
        begin
            cand_q <= cand_mem[rd_caddr];
        end
    end

endmodule

FILE: hw/rtl/hwvc_dist_unit.sv
// ----------------------------------------------------------------------------
// hwvc_dist_unit
// XOR and popcount of one word per cycle, summed into a per-row distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwvc_dist_unit #(
    parameter int ROW_BITS = 384,
    parameter int DW       = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        flush,
    input  hwvc_pkg::word_tag_t         issue_tag,
    input  logic [hwvc_pkg::WORD_W-1:0] tbl_q,
    input  logic [hwvc_pkg::WORD_W-1:0] cand_q,
    output logic                        dist_vld,
    output logic                        dist_last,
    output logic [DW-1:0]               row_dist
);
    import hwvc_pkg::*;

    localparam int ROW_WORDS = (ROW_BITS + 63) / 64;
    localparam int TAIL_BITS = ROW_BITS - (ROW_WORDS - 1) * 64;
    localparam logic [WORD_W-1:0] TAIL_MASK =
        (TAIL_BITS >= 64) ? {WORD_W{1'b1}} : ((64'd1 << TAIL_BITS) - 64'd1);

    word_tag_t         tag_reg;
    logic [DW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]     dist_reg;
    logic              dist_vld_reg, dist_last_reg;
    logic [WORD_W-1:0] diff;
    logic [POP_W-1:0]  pop;
    logic [DW-1:0]     row_sum;

    // Masked difference of the word now out of the store
    always_comb
    begin
        diff = tbl_q ^ cand_q;
        if (tag_reg.last_word)
        begin
            diff = diff & TAIL_MASK;
        end
        pop      = popcount64(diff);
        row_sum  = acc_reg + DW'(pop);
        acc_next = acc_reg;
        if (tag_reg.valid)
        begin
            acc_next = tag_reg.last_word ? '0 : row_sum;
        end
    end

    // Tag stage aligned with read data, then accumulator and row result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= '0;
            acc_reg       <= '0;
            dist_vld_reg  <= 1'b0;
            dist_last_reg <= 1'b0;
        end
        else if (flush)
        begin
            tag_reg       <= '0;
            acc_reg       <= '0;
            dist_vld_reg  <= 1'b0;
            dist_last_reg <= 1'b0;
        end
        else
        begin
            tag_reg       <= issue_tag;
            acc_reg       <= acc_next;
            dist_vld_reg  <= tag_reg.valid && tag_reg.last_word;
            dist_last_reg <= tag_reg.last_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg.valid && tag_reg.last_word)
        begin
            dist_reg <= row_sum;
        end
    end

    assign dist_vld  = dist_vld_reg;
    assign dist_last = dist_last_reg;
    assign row_dist  = dist_reg;

endmodule

FILE: hw/rtl/hwvc_window_eval.sv
// ----------------------------------------------------------------------------
// hwvc_window_eval
// Window test of each row distance, running maximum and early stop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwvc_window_eval #(
    parameter int DW = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       dist_vld,
    input  logic                       dist_last,
    input  logic [DW-1:0]              row_dist,
    input  logic [hwvc_pkg::REG_W-1:0] max_dist,
    input  logic [hwvc_pkg::REG_W-1:0] min_dist,
    input  logic [hwvc_pkg::REG_W-1:0] limit,
    output hwvc_pkg::eval_stat_t       stat
);
    import hwvc_pkg::*;

    logic [DW-1:0] err_reg, err_next;
    logic [DW-1:0] max_ext, min_ext, lim_ext;
    logic [DW-1:0] cur;
    logic          grow;

    // Excess first, shortfall only without excess
    always_comb
    begin
        max_ext = DW'(max_dist);
        min_ext = DW'(min_dist);
        lim_ext = DW'(limit);
        if (row_dist > max_ext)
        begin
            cur = row_dist - max_ext;
        end
        else if (row_dist < min_ext)
        begin
            cur = min_ext - row_dist;
        end
        else
        begin
            cur = '0;
        end
        grow     = dist_vld && (cur > err_reg);
        err_next = grow ? cur : err_reg;
        stat.done = dist_vld && ((grow && (cur >= lim_ext)) || dist_last);
        stat.violation = (err_next > DW'(VIOL_MAX)) ? VIOL_MAX : err_next[REG_W-1:0];
    end

    // Running maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= '0;
        end
        else if (start)
        begin
            err_reg <= '0;
        end
        else
        begin
            err_reg <= err_next;
        end
    end

endmodule

FILE: hw/rtl/hamming_window_violation_check.sv
// ----------------------------------------------------------------------------
// hamming_window_violation_check
// Loads table and candidate words and checks the candidate's Hamming
// distance to leading table rows against a distance window.
// ----------------------------------------------------------------------------
// A table or candidate word load is one transfer, with no result. A check
// walks ROW_WORDS words per compared row through read register, popcount and
// row sum, window evaluation and result load; an early stop ends the walk
// before the last row, and a check of zero rows loads a zero result without
// a walk. The walk is paced by the table memory's single read port, which
// delivers one 64-bit word per cycle. The item side stalls while a check
// runs. Memories have no reset and need no clearing pass: only written
// entries may be checked.
`timescale 1ns / 1ps
`include "hamming_window_violation_check_macros.svh"

module hamming_window_violation_check #(
    parameter int TABLE_ROWS = 257,
    parameter int ROW_BITS   = 384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hwvc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hwvc_pkg::REG_W-1:0]    cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    mode,
    input  logic [8:0]                    row,
    input  logic [2:0]                    word_index,
    input  logic [63:0]                   word_value,
    input  logic [8:0]                    compare_rows,
    input  logic [8:0]                    error_limit,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [8:0]                    violation
);
    import hwvc_pkg::*;

    localparam int ROW_WORDS = (ROW_BITS + 63) / 64;
    localparam int DEPTH     = TABLE_ROWS * ROW_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int DBITS     = $clog2(ROW_BITS + 1);
    localparam int DW        = (DBITS > REG_W) ? DBITS : REG_W;
    localparam int CNTW      = $clog2(TABLE_ROWS + 1);
    localparam int RIW       = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

    state_t            state_reg, state_next;
    logic [REG_W-1:0]  max_dist_reg, min_dist_reg;
    logic [REG_W-1:0]  limit_reg, limit_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     word_reg, word_next;
    logic [RIW-1:0]    rowc_reg, rowc_next;
    logic              issue_done_reg, issue_done_next;
    logic [REG_W-1:0]  res_reg, res_next;
    logic              out_vld_reg, out_vld_next;
    logic [REG_W-1:0]  out_val_reg, out_val_next;

    logic              item_xfer, out_xfer;
    logic [31:0]       wr_lin, widx32, cnt32;
    logic [CNTW-1:0]   count_eff;
    logic              tbl_we, cand_we, start;
    logic              issue;
    word_tag_t         issue_tag;
    logic [WORD_W-1:0] tbl_q, cand_q;
    logic              dist_vld, dist_last;
    logic [DW-1:0]     row_dist;
    eval_stat_t        stat;

    assign item_xfer = item_valid && !item_stall;
    assign out_xfer  = out_vld_reg && !result_stall;

    // Load decode and write addressing
    always_comb
    begin
        widx32  = 32'(word_index);
        wr_lin  = 32'(row) * 32'(ROW_WORDS) + widx32;
        cnt32   = (32'(compare_rows) > 32'(TABLE_ROWS)) ? 32'(TABLE_ROWS)
                                                       : 32'(compare_rows);
        count_eff = cnt32[CNTW-1:0];
        tbl_we  = item_xfer && (mode == MODE_TABLE) && (32'(row) < 32'(TABLE_ROWS))
                  && (widx32 < 32'(ROW_WORDS));
        cand_we = item_xfer && (mode == MODE_CAND) && (widx32 < 32'(ROW_WORDS));
        start   = item_xfer && (mode == MODE_CHECK);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= MAX_DIST_RESET;
            min_dist_reg <= MIN_DIST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_DIST: max_dist_reg <= cfg_data;
                REG_MIN_DIST: min_dist_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequencer: next state, read issue and result handoff
    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        word_next       = word_reg;
        rowc_next       = rowc_reg;
        issue_done_next = issue_done_reg;
        res_next        = res_reg;
        out_vld_next    = out_xfer ? 1'b0 : out_vld_reg;
        out_val_next    = out_val_reg;
        item_stall      = (state_reg != S_IDLE);
        issue           = 1'b0;
        issue_tag       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    limit_next      = error_limit;
                    count_next      = count_eff;
                    addr_next       = '0;
                    word_next       = '0;
                    rowc_next       = '0;
                    issue_done_next = 1'b0;
                    res_next        = '0;
                    state_next      = (count_eff == '0) ? S_WAIT : S_RUN;
                end
            end
            S_RUN:
            begin
                issue              = !issue_done_reg;
                issue_tag.valid    = issue;
                issue_tag.last_word = (word_reg == CW'(ROW_WORDS - 1));
                issue_tag.last_row = (CNTW'(rowc_reg) == (count_reg - 1'b1));
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                    if (issue_tag.last_word)
                    begin
                        word_next = '0;
                        rowc_next = rowc_reg + 1'b1;
                        if (issue_tag.last_row)
                        begin
                            issue_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
                if (stat.done)
                begin
                    res_next   = stat.violation;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!out_vld_reg || !result_stall)
                begin
                    out_vld_next = 1'b1;
                    out_val_next = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
            count_reg      <= '0;
            addr_reg       <= '0;
            word_reg       <= '0;
            rowc_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            out_vld_reg    <= out_vld_next;
            count_reg      <= count_next;
            addr_reg       <= addr_next;
            word_reg       <= word_next;
            rowc_reg       <= rowc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        limit_reg   <= limit_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
    end

    hwvc_row_store #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .CDEPTH (ROW_WORDS),
        .CW     (CW)
    ) u_store (
        .clk        (clk),
        .tbl_we     (tbl_we),
        .tbl_waddr  (wr_lin[AW-1:0]),
        .cand_we    (cand_we),
        .cand_waddr (widx32[CW-1:0]),
        .wdata      (word_value),
        .rd_en      (issue),
        .rd_taddr   (addr_reg),
        .rd_caddr   (word_reg),
        .tbl_q      (tbl_q),
        .cand_q     (cand_q)
    );

    hwvc_dist_unit #(
        .ROW_BITS (ROW_BITS),
        .DW       (DW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (stat.done),
        .issue_tag (issue_tag),
        .tbl_q     (tbl_q),
        .cand_q    (cand_q),
        .dist_vld  (dist_vld),
        .dist_last (dist_last),
        .row_dist  (row_dist)
    );

    hwvc_window_eval #(
        .DW (DW)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dist_vld  (dist_vld),
        .dist_last (dist_last),
        .row_dist  (row_dist),
        .max_dist  (max_dist_reg),
        .min_dist  (min_dist_reg),
        .limit     (limit_reg),
        .stat      (stat)
    );

    assign result_valid = out_vld_reg;
    assign violation    = out_val_reg;

    // Checks on the walk and the result handoff
    `HWVC_ASSERT_SAME(a_done_in_run, stat.done, state_reg == S_RUN, "check ended outside a walk")
    `HWVC_ASSERT_NEXT(a_done_flush, stat.done, (state_reg == S_WAIT) && !dist_vld,
        "walk not flushed after its end")
    `HWVC_ASSERT_SAME(a_load_from_wait, $rose(out_vld_reg), $past(state_reg) == S_WAIT,
        "result loaded without a finished check")

endmodule
